// ----- rtl/core/edfq_pkg.sv -----
// shared types and constants of the earliest-deadline-first ready queue
package edfq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_ENQUEUED   = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ENQUEUE  = 1'b0,
		MODE_DISPATCH = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  task_id;
		logic [31:0] arrival_time;
		logic [31:0] deadline;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_task_id;
		logic [31:0] out_deadline;
		logic [4:0]  queue_depth;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// ----- rtl/core/edf_ready_queue.sv -----
// top level of the earliest-deadline-first ready queue
//
// an item is accepted on a clock edge with start high and busy low; mode
// selects enqueue or dispatch. busy rises for one cycle while the item is
// worked on, and the result beat appears in the cycle after on result, marked
// by done for exactly one cycle. no new item is taken while busy, but a new
// item can be accepted at the same edge that ends the result beat's cycle.
// acceptance registers the item and its absolute deadline from the
// saturating adder; the work step then compares the new key against every
// cell of the sorted chain at once and shifts the chain to insert or pop
// the head.
// the receiver cannot stall: a result beat is gone after its cycle.
// reset empties the queue, clears the sequence counter and selects relative
// deadlines; no clearing pass is needed. the single register,
// deadlines_absolute, sits at byte address 0 of the apb port; the user must
// write it only while the block is idle, which the block does not enforce.
module edf_ready_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  edfq_pkg::item_t   item,
	output logic              done,
	output edfq_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	edfq_pkg::cmd_t cmd;
	logic           abs_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			abs_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == 1'b0) ? {31'd0, abs_q} : 32'd0;

	edfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	edfq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.abs_mode (abs_q),
		.item     (item),
		.result   (result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("work cycle not followed by a result beat");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.queue_depth <= 5'(edfq_pkg::DEPTH)))
		else $error("queue depth beyond capacity");

endmodule

// ----- rtl/core/edfq_ctrl.sv -----
// controller state machine of the ready queue
module edfq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output edfq_pkg::cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

endmodule

// ----- rtl/core/edfq_dp.sv -----
// datapath of the ready queue: deadline adder, sorted cell chain and result register
module edfq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  edfq_pkg::cmd_t    cmd,
	input  logic              abs_mode,
	input  edfq_pkg::item_t   item,
	output edfq_pkg::result_t result
);

	typedef struct packed {
		logic [31:0] deadline;
		logic [31:0] arrival;
		logic [7:0]  id;
		logic [31:0] seq;
	} entry_t;

	edfq_pkg::item_t          item_s1;
	logic [31:0]              abs_dl;
	logic [32:0]              dl_sum;
	entry_t                   cell_q [edfq_pkg::DEPTH];
	logic [edfq_pkg::DEPTH-1:0] lt;
	logic [edfq_pkg::CNT_W-1:0] cnt_q;
	logic [31:0]              seq_q;
	entry_t                   new_e;
	logic                     full;
	logic                     empty;
	logic                     is_enq;
	edfq_pkg::result_t        result_q;

	// absolute deadline, saturating in relative mode; a zero deadline gives the maximum
	always_comb begin
		dl_sum = {1'b0, item.arrival_time} + {1'b0, item.deadline};
		if (item.deadline == 32'd0) begin
			abs_dl = '1;
		end else if (abs_mode) begin
			abs_dl = item.deadline;
		end else if (dl_sum[32]) begin
			abs_dl = '1;
		end else begin
			abs_dl = dl_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_s1 <= '{mode: item.mode, task_id: item.task_id,
				arrival_time: item.arrival_time, deadline: abs_dl};
		end
	end

	assign new_e  = '{deadline: item_s1.deadline, arrival: item_s1.arrival_time,
		id: item_s1.task_id, seq: seq_q};
	assign full   = (cnt_q == edfq_pkg::CNT_W'(edfq_pkg::DEPTH));
	assign empty  = (cnt_q == '0);
	assign is_enq = (item_s1.mode == edfq_pkg::MODE_ENQUEUE);

	// cells ahead of the new entry in key order
	always_comb begin
		for (int i = 0; i < edfq_pkg::DEPTH; i++) begin
			lt[i] = (edfq_pkg::CNT_W'(i) < cnt_q) && (cell_q[i] < new_e);
		end
	end

	for (genvar g = 0; g < edfq_pkg::DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (is_enq && !full) begin
					if (!lt[g]) begin
						if (g == 0) begin
							cell_q[g] <= new_e;
						end else if (lt[(g == 0) ? 0 : g - 1]) begin
							cell_q[g] <= new_e;
						end else begin
							cell_q[g] <= cell_q[(g == 0) ? 0 : g - 1];
						end
					end
				end else if (!is_enq && !empty && (g < edfq_pkg::DEPTH - 1)) begin
					cell_q[g] <= cell_q[(g < edfq_pkg::DEPTH - 1) ? g + 1 : g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seq_q <= '0;
		end else if (cmd.exec) begin
			if (is_enq && !full) begin
				cnt_q <= cnt_q + 1'b1;
				seq_q <= seq_q + 32'd1;
			end else if (!is_enq && !empty) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_enq) begin
				result_q.out_task_id  <= item_s1.task_id;
				result_q.out_deadline <= item_s1.deadline;
				if (full) begin
					result_q.status      <= edfq_pkg::ST_FULL;
					result_q.queue_depth <= 5'(cnt_q);
				end else begin
					result_q.status      <= edfq_pkg::ST_ENQUEUED;
					result_q.queue_depth <= 5'(cnt_q + 1'b1);
				end
			end else if (empty) begin
				result_q.status       <= edfq_pkg::ST_EMPTY;
				result_q.out_task_id  <= '0;
				result_q.out_deadline <= '0;
				result_q.queue_depth  <= '0;
			end else begin
				result_q.status       <= edfq_pkg::ST_DISPATCHED;
				result_q.out_task_id  <= cell_q[0].id;
				result_q.out_deadline <= cell_q[0].deadline;
				result_q.queue_depth  <= 5'(cnt_q - 1'b1);
			end
		end
	end

	assign result = result_q;

endmodule
